[src/ept_pkg.sv]
// ----------------------------------------------------------------------------
// ept_pkg
// Shared types and constants of the pointer event translator.
// ----------------------------------------------------------------------------
package ept_pkg;

  // Event types
  localparam logic [4:0] EV_SYNC = 5'd0;
  localparam logic [4:0] EV_KEY  = 5'd1;
  localparam logic [4:0] EV_REL  = 5'd2;
  localparam logic [4:0] EV_ABS  = 5'd3;

  // Event codes
  localparam logic [9:0] CODE_AXIS_X     = 10'd0;
  localparam logic [9:0] CODE_AXIS_Y     = 10'd1;
  localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
  localparam logic [9:0] CODE_MT_X       = 10'd53;
  localparam logic [9:0] CODE_MT_Y       = 10'd54;
  localparam logic [9:0] CODE_META_L     = 10'd125;
  localparam logic [9:0] CODE_META_R     = 10'd126;
  localparam logic [9:0] CODE_FINGER     = 10'd325;
  localparam logic [9:0] CODE_TOUCH      = 10'd330;
  localparam logic [9:0] CODE_BTN_LEFT   = 10'd272;
  localparam logic [9:0] CODE_BTN_RIGHT  = 10'd273;
  localparam logic [9:0] CODE_BTN_MIDDLE = 10'd274;

  // Result kinds
  localparam logic [1:0] KIND_REL = 2'd0;
  localparam logic [1:0] KIND_ABS = 2'd1;
  localparam logic [1:0] KIND_BTN = 2'd2;
  localparam logic [1:0] KIND_KEY = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_AXIS_X_MIN    = 3'd2;
  localparam logic [2:0] REG_AXIS_X_MAX    = 3'd3;
  localparam logic [2:0] REG_AXIS_Y_MIN    = 3'd4;
  localparam logic [2:0] REG_AXIS_Y_MAX    = 3'd5;
  localparam logic [2:0] REG_TOUCHPAD      = 3'd6;
  localparam logic [2:0] REG_ABS_CAPABLE   = 3'd7;

  // Scaler operand widths
  localparam int DIFF_W = 33;
  localparam int MULT_W = 17;
  localparam int DEN_W  = 33;

  typedef enum logic [3:0] {
    OP_DROP,
    OP_REL_X,
    OP_REL_Y,
    OP_ABS_X,
    OP_ABS_Y,
    OP_SYNC,
    OP_META,
    OP_TOUCH,
    OP_BUTTON,
    OP_KEY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [9:0]         code;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic [14:0]        screen_width;
    logic [14:0]        screen_height;
    logic signed [31:0] axis_x_min;
    logic signed [31:0] axis_x_max;
    logic signed [31:0] axis_y_min;
    logic signed [31:0] axis_y_max;
    logic               touchpad_mode;
    logic               absolute_capable;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] diff;
    logic [MULT_W-1:0]        mult;
    logic [DEN_W-1:0]         den;
  } scl_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_EMIT
  } bk_state_t;

endpackage

[src/ept_front.sv]
// ----------------------------------------------------------------------------
// ept_front
// Accepts input events, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module ept_front
  import ept_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_cmd,
  input  logic [9:0]         in_event_code,
  input  logic signed [31:0] in_event_value,
  output logic               push,
  output entry_t             push_entry,
  input  logic               q_full
);

  logic   vld_r;
  entry_t ent_r;
  op_t    op;

  always_comb begin
    op = OP_DROP;
    unique case (in_cmd)
      EV_REL: begin
        if (in_event_code == CODE_AXIS_X) op = OP_REL_X;
        else if (in_event_code == CODE_AXIS_Y) op = OP_REL_Y;
      end
      EV_ABS: begin
        if (in_event_code == CODE_AXIS_X || in_event_code == CODE_MT_X) op = OP_ABS_X;
        else if (in_event_code == CODE_AXIS_Y || in_event_code == CODE_MT_Y) op = OP_ABS_Y;
      end
      EV_SYNC: begin
        if (in_event_code == CODE_SYN_REPORT) op = OP_SYNC;
      end
      EV_KEY: begin
        if (in_event_code == CODE_META_L || in_event_code == CODE_META_R) op = OP_META;
        else if (in_event_code == CODE_TOUCH || in_event_code == CODE_FINGER) op = OP_TOUCH;
        else if (in_event_code == CODE_BTN_LEFT || in_event_code == CODE_BTN_RIGHT ||
                 in_event_code == CODE_BTN_MIDDLE) op = OP_BUTTON;
        else op = OP_KEY;
      end
      default: op = OP_DROP;
    endcase
  end

  assign push       = vld_r;
  assign push_entry = ent_r;
  assign in_ready   = !vld_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= (op != OP_DROP);
    end else if (vld_r && !q_full) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent_r.op    <= op;
      ent_r.code  <= in_event_code;
      ent_r.value <= in_event_value;
    end
  end

endmodule

[src/ept_queue.sv]
// ----------------------------------------------------------------------------
// ept_queue
// Small request queue between the front and back parts.
// ----------------------------------------------------------------------------
module ept_queue
  import ept_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_entry;
  end

endmodule

[src/ept_scaler.sv]
// ----------------------------------------------------------------------------
// ept_scaler
// trunc(diff * mult * 2^F / den) saturated to 32 bits; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ept_scaler
  import ept_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scl_req_t           req,
  output logic               done,
  output logic signed [31:0] result
);

  localparam int PW  = DIFF_W + MULT_W;
  localparam int DVW = PW + FRACTION_BITS;
  localparam int CW  = $clog2(DVW + 1);

  logic [DVW-1:0]    dvd_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, neg_r, done_r;
  logic [DIFF_W-1:0] mag;
  logic [PW-1:0]     prod;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic              sat;

  assign mag    = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
  assign prod   = PW'(mag) * PW'(req.mult);
  assign rem_sh = {rem_r, dvd_r[DVW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= DVW'(prod) << FRACTION_BITS;
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.diff[DIFF_W-1];
    end else if (busy_r) begin
      rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      dvd_r <= {dvd_r[DVW-2:0], q_bit};
    end
  end

  // Quotient needs saturation once anything at or above bit 31 is set
  assign sat  = |dvd_r[DVW-1:31];
  assign done = done_r;

  always_comb begin
    if (!neg_r) result = sat ? 32'sh7fffffff : $signed(dvd_r[31:0]);
    else        result = sat ? 32'sh80000000 : -$signed(dvd_r[31:0]);
  end

endmodule

[src/ept_back.sv]
// ----------------------------------------------------------------------------
// ept_back
// Executes classified requests, keeps pointer state and drives the results.
// ----------------------------------------------------------------------------
module ept_back
  import ept_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  entry_t             q_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic [9:0]         out_button_or_key,
  output logic               out_pressed,
  output logic               out_is_repeat,
  output logic               out_super_held
);

  localparam logic signed [31:0] UNKNOWN = -(32'sd1 <<< FRACTION_BITS);
  localparam int RW = 32 + FRACTION_BITS;

  bk_state_t          state_r, state_nxt;
  logic signed [31:0] cur_x_r, cur_y_r, last_x_r, last_y_r;
  logic               xu_r, yu_r, touch_r, super_r;

  logic [1:0]         res_kind_r;
  logic signed [31:0] res_dx_r, res_dy_r, res_px_r, res_py_r;
  logic [9:0]         res_code_r;
  logic               res_pr_r, res_rep_r;

  logic               out_valid_r;
  logic               out_free;

  scl_req_t           scl_req;
  logic               scl_done;
  logic signed [31:0] scl_res;

  logic               pr, rep, sync_act;
  logic signed [RW-1:0] rel_sh;
  logic signed [31:0] rel_d;
  logic signed [32:0] rx_raw, ry_raw;
  logic [31:0]        rx, ry;
  logic               x_ok, y_ok;
  logic signed [31:0] x_val, y_val;

  assign pr       = (q_entry.value != 32'sd0);
  assign rep      = (q_entry.value == 32'sd2);
  assign sync_act = (xu_r || yu_r) && cfg.absolute_capable;
  assign out_free = !out_valid_r || out_ready;

  assign rel_sh = RW'(q_entry.value) <<< FRACTION_BITS;
  always_comb begin
    if ((&rel_sh[RW-1:31]) || !(|rel_sh[RW-1:31])) rel_d = rel_sh[31:0];
    else rel_d = rel_sh[RW-1] ? 32'sh80000000 : 32'sh7fffffff;
  end

  // Empty or inverted axis range counts as one
  assign rx_raw = 33'(cfg.axis_x_max) - 33'(cfg.axis_x_min);
  assign ry_raw = 33'(cfg.axis_y_max) - 33'(cfg.axis_y_min);
  assign rx     = (rx_raw <= 33'sd0) ? 32'd1 : rx_raw[31:0];
  assign ry     = (ry_raw <= 33'sd0) ? 32'd1 : ry_raw[31:0];

  assign x_ok  = cfg.touchpad_mode ? (!last_x_r[31] && !cur_x_r[31]) : !cur_x_r[31];
  assign y_ok  = cfg.touchpad_mode ? (!last_y_r[31] && !cur_y_r[31]) : !cur_y_r[31];
  assign x_val = x_ok ? scl_res : (cfg.touchpad_mode ? 32'sd0 : UNKNOWN);
  assign y_val = y_ok ? scl_res : (cfg.touchpad_mode ? 32'sd0 : UNKNOWN);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.op)
            OP_REL_X, OP_REL_Y, OP_META, OP_TOUCH, OP_BUTTON, OP_KEY:
              state_nxt = ST_EMIT;
            OP_SYNC: begin
              if (sync_act && (!cfg.touchpad_mode || touch_r)) state_nxt = ST_X_START;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_X_START: state_nxt = ST_X_WAIT;
      ST_X_WAIT:  if (scl_done) state_nxt = ST_Y_START;
      ST_Y_START: state_nxt = ST_Y_WAIT;
      ST_Y_WAIT: begin
        if (scl_done) begin
          if (!cfg.touchpad_mode || res_dx_r != 32'sd0 || y_val != 32'sd0)
            state_nxt = ST_EMIT;
          else
            state_nxt = ST_IDLE;
        end
      end
      ST_EMIT:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop           = (state_r == ST_IDLE) && q_valid;
    scl_req.start = (state_r == ST_X_START) || (state_r == ST_Y_START);
    if (state_r == ST_Y_START || state_r == ST_Y_WAIT) begin
      scl_req.diff = cfg.touchpad_mode ? 33'(cur_y_r) - 33'(last_y_r)
                                       : 33'(cur_y_r) - 33'(cfg.axis_y_min);
      scl_req.mult = cfg.touchpad_mode ? MULT_W'({cfg.screen_height, 1'b0}) +
                                         MULT_W'(cfg.screen_height)
                                       : MULT_W'(cfg.screen_height);
      scl_req.den  = cfg.touchpad_mode ? {ry, 1'b0} : {1'b0, ry};
    end else begin
      scl_req.diff = cfg.touchpad_mode ? 33'(cur_x_r) - 33'(last_x_r)
                                       : 33'(cur_x_r) - 33'(cfg.axis_x_min);
      scl_req.mult = cfg.touchpad_mode ? MULT_W'({cfg.screen_width, 1'b0}) +
                                         MULT_W'(cfg.screen_width)
                                       : MULT_W'(cfg.screen_width);
      scl_req.den  = cfg.touchpad_mode ? {rx, 1'b0} : {1'b0, rx};
    end
  end

  ept_scaler #(.FRACTION_BITS(FRACTION_BITS)) u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (scl_req),
    .done   (scl_done),
    .result (scl_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_x_r     <= -32'sd1;
      cur_y_r     <= -32'sd1;
      last_x_r    <= -32'sd1;
      last_y_r    <= -32'sd1;
      xu_r        <= 1'b0;
      yu_r        <= 1'b0;
      touch_r     <= 1'b0;
      super_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        unique case (q_entry.op)
          OP_ABS_X: begin
            cur_x_r <= q_entry.value;
            xu_r    <= 1'b1;
          end
          OP_ABS_Y: begin
            cur_y_r <= q_entry.value;
            yu_r    <= 1'b1;
          end
          OP_SYNC: begin
            if (sync_act) begin
              xu_r <= 1'b0;
              yu_r <= 1'b0;
            end
          end
          OP_META: super_r <= pr;
          OP_TOUCH: begin
            touch_r  <= pr;
            last_x_r <= pr ? cur_x_r : -32'sd1;
            last_y_r <= pr ? cur_y_r : -32'sd1;
          end
          default: ;
        endcase
      end
      // Touchpad: last position follows the current one after each report
      if (state_r == ST_Y_WAIT && scl_done && cfg.touchpad_mode) begin
        last_x_r <= cur_x_r;
        last_y_r <= cur_y_r;
      end
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (pop) begin
      res_kind_r <= KIND_KEY;
      res_dx_r   <= 32'sd0;
      res_dy_r   <= 32'sd0;
      res_px_r   <= UNKNOWN;
      res_py_r   <= UNKNOWN;
      res_code_r <= q_entry.code;
      res_pr_r   <= pr;
      res_rep_r  <= rep;
      unique case (q_entry.op)
        OP_REL_X, OP_REL_Y, OP_SYNC: begin
          res_kind_r <= (q_entry.op == OP_SYNC && !cfg.touchpad_mode) ? KIND_ABS : KIND_REL;
          res_code_r <= '0;
          res_pr_r   <= 1'b0;
          res_rep_r  <= 1'b0;
          if (q_entry.op == OP_REL_X) res_dx_r <= rel_d;
          if (q_entry.op == OP_REL_Y) res_dy_r <= rel_d;
        end
        OP_TOUCH: begin
          res_kind_r <= KIND_BTN;
          res_code_r <= CODE_BTN_LEFT;
        end
        OP_BUTTON: res_kind_r <= KIND_BTN;
        default:   res_kind_r <= KIND_KEY;
      endcase
    end
    if (state_r == ST_X_WAIT && scl_done) begin
      if (cfg.touchpad_mode) res_dx_r <= x_val;
      else res_px_r <= x_val;
    end
    if (state_r == ST_Y_WAIT && scl_done) begin
      if (cfg.touchpad_mode) res_dy_r <= y_val;
      else res_py_r <= y_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_kind          <= res_kind_r;
      out_delta_x       <= res_dx_r;
      out_delta_y       <= res_dy_r;
      out_position_x    <= res_px_r;
      out_position_y    <= res_py_r;
      out_button_or_key <= res_code_r;
      out_pressed       <= res_pr_r;
      out_is_repeat     <= res_rep_r;
      out_super_held    <= super_r;
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    scl_done |-> (state_r == ST_X_WAIT || state_r == ST_Y_WAIT))
    else $error("scaler finished outside a wait state");

  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_X_START || state_r == ST_X_WAIT || state_r == ST_Y_START ||
     state_r == ST_Y_WAIT) |-> (!xu_r && !yu_r))
    else $error("axis update flags set during a sync report");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded on emit");

endmodule

[src/evdev_pointer_event_translator_core.sv]
// ----------------------------------------------------------------------------
// evdev_pointer_event_translator_core
// Turns input-device events into pointer motion, button and key results.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      in         in_valid/in_ready  cmd, event_code, event_value
//  out_     out        out_valid/out_ready kind, deltas, positions, key, flags
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
//  A non-sync request passes the front register, the queue, the back staging
//  and the output register. A sync report that acts on pending axis updates
//  runs the shared scaler twice, once per axis; one quotient bit per cycle.
//  Reset is synchronous, active low; state and config take their reset values.
//  A stalled output holds the back part; the queue keeps the front accepting until it fills.
// ----------------------------------------------------------------------------
module evdev_pointer_event_translator_core
  import ept_pkg::*;
#(
  parameter int FRACTION_BITS = 8,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_cmd,
  input  logic [9:0]         in_event_code,
  input  logic signed [31:0] in_event_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic [9:0]         out_button_or_key,
  output logic               out_pressed,
  output logic               out_is_repeat,
  output logic               out_super_held,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t   cfg_r;
  logic   push, q_full, pop, q_valid;
  entry_t push_entry, q_entry;

  // Config registers; the user must write them only while the block is idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width     <= 15'd1920;
      cfg_r.screen_height    <= 15'd1080;
      cfg_r.axis_x_min       <= 32'sd0;
      cfg_r.axis_x_max       <= 32'sd1;
      cfg_r.axis_y_min       <= 32'sd0;
      cfg_r.axis_y_max       <= 32'sd1;
      cfg_r.touchpad_mode    <= 1'b0;
      cfg_r.absolute_capable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width     <= cfg_data[14:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height    <= cfg_data[14:0];
        REG_AXIS_X_MIN:    cfg_r.axis_x_min       <= $signed(cfg_data);
        REG_AXIS_X_MAX:    cfg_r.axis_x_max       <= $signed(cfg_data);
        REG_AXIS_Y_MIN:    cfg_r.axis_y_min       <= $signed(cfg_data);
        REG_AXIS_Y_MAX:    cfg_r.axis_y_max       <= $signed(cfg_data);
        REG_TOUCHPAD:      cfg_r.touchpad_mode    <= cfg_data[0];
        REG_ABS_CAPABLE:   cfg_r.absolute_capable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify, drop events with no effect
  ept_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_event_code  (in_event_code),
    .in_event_value (in_event_value),
    .push           (push),
    .push_entry     (push_entry),
    .q_full         (q_full)
  );

  // Queue: decouple the front from the slow back part
  ept_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // Back: hold pointer state, scale, and drive results
  ept_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_position_x    (out_position_x),
    .out_position_y    (out_position_y),
    .out_button_or_key (out_button_or_key),
    .out_pressed       (out_pressed),
    .out_is_repeat     (out_is_repeat),
    .out_super_held    (out_super_held)
  );

endmodule
